### design/sspg_pkg.sv
// Shared types, constants and helpers for the stepper speed-ramp pulse generator.
package sspg_pkg;

    // Field and register widths
    localparam int ALIM_W    = 10;
    localparam int SLIM_W    = 15;
    localparam int NUM_W     = 22;
    localparam int SPEED_W   = 16;
    localparam int RATE_W    = 11;
    localparam int MAG_W     = 15;
    localparam int ACCEL_W   = 16;
    localparam int CMD_W     = 2;
    localparam int OUT_W     = 40;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    // Command queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    // Divider: one quotient bit per cycle
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(NUM_W);

    // Speed constants, hundredths of rpm
    localparam logic [SLIM_W-1:0]         SPEED_RANGE = 15'd30000;
    localparam logic [MAG_W-1:0]          MIN_MAG     = 15'd100;
    localparam logic signed [SPEED_W-1:0] SPEED_RST   = 16'sd6000;

    // Register reset values
    localparam logic [ALIM_W-1:0] ACCEL_LIMIT_RST = 10'd250;
    localparam logic [SLIM_W-1:0] SPEED_LIMIT_RST = 15'd15000;
    localparam logic [NUM_W-1:0]  PERIOD_NUM_RST  = 22'd1875000;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_LIMIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD_NUM  = 2'd2;

    // Command codes on the input beat
    localparam logic [CMD_W-1:0] CMD_SET_ACCEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CTRL_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_USEC_TICK = 2'd2;

    // Classified operation carried through the queue
    typedef enum logic [1:0] {
        OP_ACCEL,
        OP_CTRL,
        OP_USEC,
        OP_REPORT
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [RATE_W-1:0] rate;
    } t_q_item;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAG,
        ST_DIV
    } t_back_state;

    // Clamp a signed acceleration to +/- lim
    function automatic logic signed [RATE_W-1:0] sat_rate(
        input logic signed [ACCEL_W-1:0] a,
        input logic [ALIM_W-1:0]         lim
    );
        logic signed [ACCEL_W:0] v_a;
        logic signed [ACCEL_W:0] v_l;
        logic signed [ACCEL_W:0] v_r;
        v_a = {a[ACCEL_W-1], a};
        v_l = {{(ACCEL_W+1-ALIM_W){1'b0}}, lim};
        if (v_a > v_l) begin
            v_r = v_l;
        end else if (v_a < -v_l) begin
            v_r = -v_l;
        end else begin
            v_r = v_a;
        end
        return v_r[RATE_W-1:0];
    endfunction

endpackage

### design/sspg_front.sv
// Front end: takes input beats, classifies the command and saturates the acceleration.
module sspg_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [1:0]                    s_axis_tuser,   // [1:0] cmd
    input  logic [15:0]                   s_axis_tdata,   // [15:0] accel_value
    input  logic [sspg_pkg::ALIM_W-1:0]   i_accel_limit,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output sspg_pkg::t_q_item             o_q_item
);
    import sspg_pkg::*;

    // Accept whenever the queue has room
    assign s_axis_tready = ~i_q_full;
    assign o_q_push      = s_axis_tvalid & ~i_q_full;

    // Decode command and pre-saturate the requested rate
    always_comb begin
        o_q_item.rate = sat_rate(s_axis_tdata, i_accel_limit);
        case (s_axis_tuser)
            CMD_SET_ACCEL: o_q_item.op = OP_ACCEL;
            CMD_CTRL_TICK: o_q_item.op = OP_CTRL;
            CMD_USEC_TICK: o_q_item.op = OP_USEC;
            default:       o_q_item.op = OP_REPORT;
        endcase
    end

endmodule

### design/sspg_fifo.sv
// Short command queue decoupling the front end from the execution back end.
module sspg_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sspg_pkg::t_q_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output sspg_pkg::t_q_item o_item
);
    import sspg_pkg::*;

    t_q_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

### design/sspg_div.sv
// Restoring divider, one quotient bit per cycle: step period = numerator / |speed|.
module sspg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sspg_pkg::NUM_W-1:0]  i_num,
    input  logic [sspg_pkg::MAG_W-1:0]  i_den,
    output sspg_pkg::t_div_rsp          o_rsp
);
    import sspg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_quo;
    logic [MAG_W-1:0]     r_rem;
    logic [MAG_W-1:0]     r_den;
    logic [MAG_W:0]       w_trial;
    logic                 w_fit;
    logic [MAG_W:0]       w_diff;

    // Shift in next dividend bit and try subtracting
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[MAG_W-1:0] : w_trial[MAG_W-1:0];
        end
    end

endmodule

### design/sspg_back.sv
// Back end: executes queued commands, holds ramp and waveform state, drives result beats.
module sspg_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  sspg_pkg::t_q_item           i_q_item,
    output logic                        o_q_pop,
    input  logic [sspg_pkg::ALIM_W-1:0] i_accel_limit,
    input  logic [sspg_pkg::SLIM_W-1:0] i_speed_limit,
    input  logic [sspg_pkg::NUM_W-1:0]  i_period_num,
    output logic                        o_div_start,
    output logic [sspg_pkg::NUM_W-1:0]  o_div_num,
    output logic [sspg_pkg::MAG_W-1:0]  o_div_den,
    input  sspg_pkg::t_div_rsp          i_div_rsp,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] step_out, [1] dir_out, [17:2] speed_now, [39:18] period_now
    output logic [sspg_pkg::OUT_W-1:0]  m_axis_tdata
);
    import sspg_pkg::*;

    t_back_state               r_state,  n_state;
    logic signed [SPEED_W-1:0] r_speed,  n_speed;
    logic signed [RATE_W-1:0]  r_rate,   n_rate;
    logic [NUM_W-1:0]          r_period, n_period;
    logic [NUM_W-1:0]          r_phase,  n_phase;
    logic                      r_level,  n_level;
    logic                      r_out_valid, n_out_valid;
    logic [OUT_W-1:0]          r_out_data,  n_out_data;
    logic                      w_load;
    logic                      w_out_free;

    // Control tick datapath
    logic signed [RATE_W-1:0]  w_resat;
    logic [SLIM_W-1:0]         w_lim;
    logic signed [SPEED_W:0]   w_lim_x;
    logic signed [SPEED_W:0]   w_sum;
    logic                      w_rate_pos;
    logic                      w_rate_neg;
    logic signed [SPEED_W-1:0] w_speed_new;
    logic [SPEED_W-1:0]        w_abs;
    logic [MAG_W-1:0]          w_mag;

    // Microsecond tick datapath
    logic [NUM_W-2:0]          w_half;
    logic [NUM_W-2:0]          w_half_eff;
    logic [NUM_W-1:0]          w_full;
    logic [NUM_W:0]            w_inc;
    logic                      w_stop;
    logic                      w_usec_level;
    logic [NUM_W-1:0]          w_usec_phase;

    assign w_out_free    = ~r_out_valid | m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_div_num     = i_period_num;
    assign o_div_den     = w_mag;

    // Resaturate the rate, add it, clamp to the speed limit
    always_comb begin
        w_resat    = sat_rate({{(ACCEL_W-RATE_W){r_rate[RATE_W-1]}}, r_rate}, i_accel_limit);
        w_lim      = (i_speed_limit > SPEED_RANGE) ? SPEED_RANGE : i_speed_limit;
        w_lim_x    = {{(SPEED_W+1-SLIM_W){1'b0}}, w_lim};
        w_sum      = {r_speed[SPEED_W-1], r_speed}
                   + {{(SPEED_W+1-RATE_W){w_resat[RATE_W-1]}}, w_resat};
        w_rate_neg = w_resat[RATE_W-1];
        w_rate_pos = ~w_resat[RATE_W-1] & (w_resat != '0);
        if (w_rate_pos && (w_sum > w_lim_x)) begin
            w_speed_new = w_lim_x[SPEED_W-1:0];
        end else if (w_rate_neg && (w_sum < -w_lim_x)) begin
            w_speed_new = -w_lim_x[SPEED_W-1:0];
        end else if (w_resat == '0) begin
            w_speed_new = r_speed;
        end else begin
            w_speed_new = w_sum[SPEED_W-1:0];
        end
    end

    // Speed magnitude, fits in 15 bits since |speed| <= 30000
    assign w_abs = r_speed[SPEED_W-1] ? -r_speed : r_speed;
    assign w_mag = w_abs[MAG_W-1:0];

    // Square wave: high for half a period, low for half; period 1 counts as half of 1
    always_comb begin
        w_half       = r_period[NUM_W-1:1];
        w_half_eff   = (w_half == '0) ? (NUM_W-1)'(1) : w_half;
        w_full       = {w_half_eff, 1'b0};
        w_inc        = {1'b0, r_phase} + 1'b1;
        w_stop       = (r_speed == '0) || (r_period == '0);
        if (w_stop) begin
            w_usec_level = 1'b0;
            w_usec_phase = '0;
        end else begin
            w_usec_level = (r_phase < {1'b0, w_half_eff});
            w_usec_phase = (w_inc >= {1'b0, w_full}) ? '0 : w_inc[NUM_W-1:0];
        end
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state     = r_state;
        n_speed     = r_speed;
        n_rate      = r_rate;
        n_period    = r_period;
        n_phase     = r_phase;
        n_level     = r_level;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_data  = r_out_data;
        w_load      = 1'b0;
        o_q_pop     = 1'b0;
        o_div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    o_q_pop = 1'b1;
                    case (i_q_item.op)
                        OP_ACCEL: begin
                            n_rate = i_q_item.rate;
                            w_load = 1'b1;
                        end
                        OP_CTRL: begin
                            n_rate  = w_resat;
                            n_speed = w_speed_new;
                            n_state = ST_MAG;
                        end
                        OP_USEC: begin
                            n_level = w_usec_level;
                            n_phase = w_usec_phase;
                            w_load  = 1'b1;
                        end
                        default: w_load = 1'b1;
                    endcase
                end
            end
            ST_MAG: begin
                if (w_mag >= MIN_MAG) begin
                    o_div_start = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (i_div_rsp.done) begin
                    n_period = i_div_rsp.quot;
                    w_load   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_data  = {n_period, n_speed, n_speed[SPEED_W-1], n_level};
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_speed     <= SPEED_RST;
            r_rate      <= '0;
            r_period    <= '0;
            r_phase     <= '0;
            r_level     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_speed     <= n_speed;
            r_rate      <= n_rate;
            r_period    <= n_period;
            r_phase     <= n_phase;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

### design/stepper_speed_ramp_pulse_gen_unit.sv
// Stepper speed-ramp pulse generator top level: registers, queue, front and back ends.
// Every input beat gives exactly one result beat with the step level, direction, speed and
// step period after that command. Beats enter a two-deep queue; the back end takes one
// command at a time. Set-acceleration, microsecond-tick and unused commands leave the back
// end in the cycle after they are taken from the queue. A control tick passes through the
// MAG state, and the DIV state too when |speed| is at least 1 rpm, because the new period
// comes from a divider that yields one quotient bit per cycle over 22 bits. A command is
// taken from the queue only when the result register is empty or is being read in that
// cycle, so a stalled result holds the back end while the queue keeps taking beats until
// it is full. Registers accel_limit, speed_limit and period_numerator sit at APB byte
// addresses 0x0, 0x4 and 0x8 and are to be written only while the block is idle.
module stepper_speed_ramp_pulse_gen_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [1:0]                  s_axis_tuser,   // [1:0] cmd
    input  logic [15:0]                 s_axis_tdata,   // [15:0] accel_value
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] step_out, [1] dir_out, [17:2] speed_now, [39:18] period_now
    output logic [sspg_pkg::OUT_W-1:0]  m_axis_tdata,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sspg_pkg::ADDR_W-1:0] paddr,
    input  logic [sspg_pkg::APB_W-1:0]  pwdata,
    output logic [sspg_pkg::APB_W-1:0]  prdata,
    output logic                        pready
);
    import sspg_pkg::*;

    logic [ALIM_W-1:0]    r_accel_limit;
    logic [SLIM_W-1:0]    r_speed_limit;
    logic [NUM_W-1:0]     r_period_num;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_wr;

    logic                 w_q_full;
    logic                 w_q_push;
    t_q_item              w_push_item;
    logic                 w_q_valid;
    logic                 w_q_pop;
    t_q_item              w_head_item;
    logic                 w_div_start;
    logic [NUM_W-1:0]     w_div_num;
    logic [MAG_W-1:0]     w_div_den;
    t_div_rsp             w_div_rsp;

    // Register file
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_wr      = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_limit <= ACCEL_LIMIT_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
            r_period_num  <= PERIOD_NUM_RST;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_ACCEL_LIMIT: r_accel_limit <= pwdata[ALIM_W-1:0];
                REG_SPEED_LIMIT: r_speed_limit <= pwdata[SLIM_W-1:0];
                REG_PERIOD_NUM:  r_period_num  <= pwdata[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_ACCEL_LIMIT: prdata = {{(APB_W-ALIM_W){1'b0}}, r_accel_limit};
            REG_SPEED_LIMIT: prdata = {{(APB_W-SLIM_W){1'b0}}, r_speed_limit};
            REG_PERIOD_NUM:  prdata = {{(APB_W-NUM_W){1'b0}}, r_period_num};
            default:         prdata = '0;
        endcase
    end

    // Front end
    sspg_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .i_accel_limit (r_accel_limit),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_item      (w_push_item)
    );

    // Command queue
    sspg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_head_item)
    );

    // Period divider
    sspg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_rsp   (w_div_rsp)
    );

    // Back end
    sspg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_head_item),
        .o_q_pop       (w_q_pop),
        .i_accel_limit (r_accel_limit),
        .i_speed_limit (r_speed_limit),
        .i_period_num  (r_period_num),
        .o_div_start   (w_div_start),
        .o_div_num     (w_div_num),
        .o_div_den     (w_div_den),
        .i_div_rsp     (w_div_rsp),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### design/sspg_checker.sv
// Port-level checker for the stepper speed-ramp pulse generator, bound to the top level.
module sspg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [sspg_pkg::OUT_W-1:0]  m_axis_tdata
);
    import sspg_pkg::*;

    logic signed [SPEED_W-1:0] w_speed;

    assign w_speed = m_axis_tdata[SPEED_W+1:2];

    // A result beat stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped before acceptance");

    // Direction bit follows the sign of the reported speed
    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1] == m_axis_tdata[SPEED_W+1]))
        else $error("direction disagrees with speed sign");

    // Reported speed never leaves the +/- 300 rpm range
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_speed <= 16'sd30000) && (w_speed >= -16'sd30000))
        else $error("speed out of range");

    // Reset empties the result register
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind stepper_speed_ramp_pulse_gen_unit sspg_checker u_sspg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
